// ===== hdl/bnp_pkg.sv =====
// ----------------------------------------------------------------------------
// bnp_pkg
// Shared constants, codes and types for the buzzer note player.
// ----------------------------------------------------------------------------
package bnp_pkg;

   localparam int unsigned TIMER_CLOCK_HZ = 2000000;

   // quotient width of the timer clock divide
   localparam int unsigned DIV_W     = $clog2(TIMER_CLOCK_HZ + 1);
   localparam int unsigned DIV_CNT_W = $clog2(DIV_W);
   localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(TIMER_CLOCK_HZ);

   // divide by ten as multiply by reciprocal, exact for 16-bit operands
   localparam logic [15:0] RECIP_TEN   = 16'd52429;
   localparam int unsigned RECIP_SHIFT = 19;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_MS   = 2'd2;

   typedef logic [1:0] phase_type;

   localparam phase_type PH_IDLE = 2'd0;
   localparam phase_type PH_TONE = 2'd1;
   localparam phase_type PH_GAP  = 2'd2;
   localparam phase_type PH_REST = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== hdl/buzzer_note_player.sv =====
// ----------------------------------------------------------------------------
// buzzer_note_player
// Square-wave tone generator with a one-note sequencer.
// ----------------------------------------------------------------------------
// Usage: each request transaction carries an opcode (load note, timer tick,
// millisecond tick) and the note fields; each one yields exactly one response
// transaction with the pin level, the play phase and the rejected and
// song_done flags as they stand after that request.
// The response is registered: it appears the cycle after the request is
// accepted. Ticks and rests are taken one per cycle while req_ready is high.
// A note load that starts a tone launches the restoring divider for the
// compare value; it works through all DIV_W quotient bits and then stores
// the result, and req_ready stays low until the result is stored.
// While the response register holds an untaken transaction and rsp_ready is
// low, req_ready is low; a response taken in the same cycle frees room for a
// new request at once.
// Reset (synchronous) returns the player to idle with the pin low and empties
// the response register.
// ----------------------------------------------------------------------------
module buzzer_note_player (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_note_freq,
   input  logic [15:0] req_note_duration_ms,
   input  logic        req_last_note,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_pin_level,
   output logic [1:0]  rsp_phase,
   output logic        rsp_rejected,
   output logic        rsp_song_done
);
   import bnp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] top_ff, top_in;
   logic [15:0] tone_cnt_ff, tone_cnt_in;
   logic [15:0] ms_cnt_ff, ms_cnt_in;
   logic [15:0] sound_ms_ff, sound_ms_in;
   logic [15:0] gap_ms_ff, gap_ms_in;
   logic        pin_ff, pin_in;
   logic        final_ff, final_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_pin_ff;
   phase_type   rsp_phase_ff;
   logic        rsp_rej_ff;
   logic        rsp_done_ff;

   logic           accept;
   logic           rejected;
   logic           done;
   logic           div_start;
   div_status_type div_status;
   logic [DIV_W-1:0] quotient;
   logic [31:0]    recip_prod;
   logic [15:0]    gap_calc;
   logic [15:0]    ms_inc;
   logic [31:0]    quo_ext;

   bnp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (req_note_freq),
      .status   (div_status),
      .quotient (quotient)
   );

   assign req_ready  = !div_status.busy && !div_status.done && (!rsp_valid_ff || rsp_ready);
   assign accept     = req_valid && req_ready;
   assign recip_prod = 32'(req_note_duration_ms) * 32'(RECIP_TEN);
   assign gap_calc   = 16'(recip_prod >> RECIP_SHIFT);
   assign ms_inc     = ms_cnt_ff + 16'd1;
   assign quo_ext    = 32'(quotient);

   always_comb begin
      phase_in    = phase_ff;
      top_in      = top_ff;
      tone_cnt_in = tone_cnt_ff;
      ms_cnt_in   = ms_cnt_ff;
      sound_ms_in = sound_ms_ff;
      gap_ms_in   = gap_ms_ff;
      pin_in      = pin_ff;
      final_in    = final_ff;
      rejected    = 1'b0;
      done        = 1'b0;
      div_start   = 1'b0;

      // compare value from the divider, saturated to 16 bits
      if (div_status.done) begin
         if (quo_ext == 32'd0) begin
            top_in = 16'd0;
         end else if ((quo_ext - 32'd1) > 32'd65535) begin
            top_in = 16'hFFFF;
         end else begin
            top_in = 16'(quo_ext - 32'd1);
         end
      end

      if (accept) begin
         unique case (req_opcode)
            OP_LOAD: begin
               if (phase_ff != PH_IDLE) begin
                  rejected = 1'b1;
               end else begin
                  final_in  = req_last_note;
                  ms_cnt_in = 16'd0;
                  pin_in    = 1'b0;
                  if (req_note_duration_ms == 16'd0) begin
                     done     = req_last_note;
                     final_in = 1'b0;
                  end else if (req_note_freq == 16'd0) begin
                     phase_in    = PH_REST;
                     sound_ms_in = req_note_duration_ms;
                     gap_ms_in   = 16'd0;
                  end else begin
                     phase_in    = PH_TONE;
                     gap_ms_in   = gap_calc;
                     sound_ms_in = req_note_duration_ms - gap_calc;
                     tone_cnt_in = 16'd0;
                     div_start   = 1'b1;
                  end
               end
            end
            OP_TICK: begin
               if (phase_ff == PH_TONE) begin
                  if (tone_cnt_ff == top_ff) begin
                     tone_cnt_in = 16'd0;
                     pin_in      = !pin_ff;
                  end else begin
                     tone_cnt_in = tone_cnt_ff + 16'd1;
                  end
               end
            end
            OP_MS: begin
               if (phase_ff != PH_IDLE) begin
                  ms_cnt_in = ms_inc;
                  unique case (phase_ff)
                     PH_TONE: begin
                        if (ms_inc >= sound_ms_ff) begin
                           pin_in    = 1'b0;
                           ms_cnt_in = 16'd0;
                           if (gap_ms_ff != 16'd0) begin
                              phase_in = PH_GAP;
                           end else begin
                              done     = final_ff;
                              phase_in = PH_IDLE;
                              final_in = 1'b0;
                           end
                        end
                     end
                     PH_GAP: begin
                        if (ms_inc >= gap_ms_ff) begin
                           done      = final_ff;
                           phase_in  = PH_IDLE;
                           pin_in    = 1'b0;
                           ms_cnt_in = 16'd0;
                           final_in  = 1'b0;
                        end
                     end
                     default: begin
                        if (ms_inc >= sound_ms_ff) begin
                           done      = final_ff;
                           phase_in  = PH_IDLE;
                           pin_in    = 1'b0;
                           ms_cnt_in = 16'd0;
                           final_in  = 1'b0;
                        end
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end

      // response register
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         top_ff       <= 16'd0;
         tone_cnt_ff  <= 16'd0;
         ms_cnt_ff    <= 16'd0;
         sound_ms_ff  <= 16'd0;
         gap_ms_ff    <= 16'd0;
         pin_ff       <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         top_ff       <= top_in;
         tone_cnt_ff  <= tone_cnt_in;
         ms_cnt_ff    <= ms_cnt_in;
         sound_ms_ff  <= sound_ms_in;
         gap_ms_ff    <= gap_ms_in;
         pin_ff       <= pin_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_pin_ff   <= pin_in;
         rsp_phase_ff <= phase_in;
         rsp_rej_ff   <= rejected;
         rsp_done_ff  <= done;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pin_level = rsp_pin_ff;
   assign rsp_phase     = rsp_phase_ff;
   assign rsp_rejected  = rsp_rej_ff;
   assign rsp_song_done = rsp_done_ff;

endmodule

// ===== hdl/bnp_divider.sv =====
// ----------------------------------------------------------------------------
// bnp_divider
// Restoring divider, one quotient bit per cycle: timer clock / divisor.
// ----------------------------------------------------------------------------
module bnp_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [15:0]                divisor,
   output bnp_pkg::div_status_type    status,
   output logic [bnp_pkg::DIV_W-1:0]  quotient
);
   import bnp_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]          rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [15:0]          dvs_ff, dvs_in;

   logic [16:0] trial;
   logic [16:0] diff;
   logic        ge;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DIV_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = '0;
         dvd_in  = DIVIDEND;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[15:0] : trial[15:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule
